@@ src/maze_spanning_tree_merge_assert.svh @@
// ----------------------------------------------------------------------------
// Maze spanning tree merge: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef MAZE_SPANNING_TREE_MERGE_ASSERT_SVH
`define MAZE_SPANNING_TREE_MERGE_ASSERT_SVH

// Property that must hold in the same cycle as its antecedent.
`define MSTM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define MSTM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) else $error(msg);

`endif

@@ src/mstm_pkg.sv @@
// ----------------------------------------------------------------------------
// Maze spanning tree merge: package
// Field widths, grid size, status and command codes, and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package mstm_pkg;

  // Grid capacity. The label store holds one entry per cell of the full grid.
  localparam int MaxRows  = 32;
  localparam int MaxCols  = 32;
  localparam int NumCells = MaxRows * MaxCols;
  localparam int CellW    = $clog2(NumCells);

  // Field widths.
  localparam int RowW    = 5;
  localparam int ColW    = 5;
  localparam int DimW    = 6;
  localparam int CountW  = 11;
  localparam int StatusW = 3;
  localparam int CfgIdxW = 2;
  localparam int WideW   = CellW + DimW;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_ROWS = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_COLS = 2'd1;

  // Command kinds and edge directions.
  localparam logic KIND_CLEAR = 1'b0;
  localparam logic KIND_EDGE  = 1'b1;
  localparam logic DIR_RIGHT  = 1'b0;
  localparam logic DIR_DOWN   = 1'b1;

  typedef enum logic [StatusW-1:0] {
    ST_ACCEPTED     = 3'd0,
    ST_SAME_CLUSTER = 3'd1,
    ST_OUT_OF_GRID  = 3'd2,
    ST_COMPLETE     = 3'd3,
    ST_CLEARED      = 3'd4
  } status_e;

  // Decoded edge: its two label addresses and whether it leaves the grid.
  typedef struct packed {
    logic             out_of_grid;
    logic [CellW-1:0] addr_a;
    logic [CellW-1:0] addr_b;
  } edge_t;

  // Zero counts as one, anything above the capacity counts as the capacity.
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                input logic [DimW-1:0] maxv);
    logic [DimW-1:0] r;
    r = v;
    if (r == '0) begin
      r = DimW'(1);
    end
    if (r > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

  function automatic logic [CellW-1:0] cell_index(input logic [DimW-1:0] row,
                                                  input logic [DimW-1:0] col);
    logic [WideW-1:0] full;
    full = WideW'(row) * WideW'(MaxCols) + WideW'(col);
    return full[CellW-1:0];
  endfunction

endpackage

`default_nettype wire

@@ src/mstm_edge_decode.sv @@
// ----------------------------------------------------------------------------
// Maze spanning tree merge: edge decoder
// Finds the neighbor cell of an edge, checks both ends against the grid in
// use and forms the label store addresses of the two cells.
// ----------------------------------------------------------------------------
`default_nettype none

module mstm_edge_decode (
  input  wire logic [mstm_pkg::RowW-1:0] cell_row_i,
  input  wire logic [mstm_pkg::ColW-1:0] cell_col_i,
  input  wire logic                      direction_i,
  input  wire logic [mstm_pkg::DimW-1:0] num_rows_i,
  input  wire logic [mstm_pkg::DimW-1:0] num_cols_i,
  output mstm_pkg::edge_t                edge_o
);

  logic                      down;
  logic [mstm_pkg::DimW-1:0] row_a;
  logic [mstm_pkg::DimW-1:0] col_a;
  logic [mstm_pkg::DimW-1:0] row_b;
  logic [mstm_pkg::DimW-1:0] col_b;

  assign down  = (direction_i == mstm_pkg::DIR_DOWN);
  assign row_a = mstm_pkg::DimW'(cell_row_i);
  assign col_a = mstm_pkg::DimW'(cell_col_i);
  assign row_b = row_a + mstm_pkg::DimW'(down);
  assign col_b = col_a + mstm_pkg::DimW'(!down);

  // The neighbor lies at or beyond the first cell, so checking it covers both.
  assign edge_o.out_of_grid = (row_b >= num_rows_i) || (col_b >= num_cols_i);
  assign edge_o.addr_a      = mstm_pkg::cell_index(row_a, col_a);
  assign edge_o.addr_b      = mstm_pkg::cell_index(row_b, col_b);

endmodule

`default_nettype wire

@@ src/maze_spanning_tree_merge.sv @@
// ----------------------------------------------------------------------------
// Maze spanning tree merge
// Cluster labels of a maze grid kept in one label memory; edges merge
// clusters by relabeling every entry of the absorbed cluster.
// ----------------------------------------------------------------------------
// Edge refused as complete or out of grid: result in the cycle after start,
// busy stays low. Edge inside one cluster: result after states READ_B and
// COMPARE. Merging edge: result after the relabel sweep over the label memory
// at one entry per cycle. Clear: one write per entry.
// After reset, and after every write to the rows or cols register, a clearing
// pass runs with busy high; results are never stalled by the receiver.
`default_nettype none

`include "maze_spanning_tree_merge_assert.svh"

module maze_spanning_tree_merge (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic                         kind_i,
  input  wire logic [mstm_pkg::RowW-1:0]    cell_row_i,
  input  wire logic [mstm_pkg::ColW-1:0]    cell_col_i,
  input  wire logic                         direction_i,
  output logic                              done_o,
  output logic [mstm_pkg::StatusW-1:0]      status_o,
  output logic                              maze_done_o,
  output logic [mstm_pkg::CountW-1:0]       clusters_left_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [mstm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [mstm_pkg::DimW-1:0]    cfg_data_i
);

  localparam int CellW  = mstm_pkg::CellW;
  localparam int DimW   = mstm_pkg::DimW;
  localparam int CountW = mstm_pkg::CountW;
  localparam logic [CellW-1:0] LastCell = CellW'(mstm_pkg::NumCells - 1);
  localparam logic [DimW-1:0]  RowsCap  = DimW'(mstm_pkg::MaxRows);
  localparam logic [DimW-1:0]  ColsCap  = DimW'(mstm_pkg::MaxCols);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_CLEAR   = 5'b00010,
    S_READ_B  = 5'b00100,
    S_COMPARE = 5'b01000,
    S_MERGE   = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [CellW-1:0]  idx_q, idx_d;
  logic [CellW-1:0]  a_q, a_d;
  logic [CellW-1:0]  b_q, b_d;
  logic [CellW-1:0]  addr_b_q, addr_b_d;
  logic              report_q, report_d;
  logic [CountW-1:0] count_q, count_d;
  logic [DimW-1:0]   rows_q, rows_d;
  logic [DimW-1:0]   cols_q, cols_d;
  logic              done_q, done_d;
  mstm_pkg::status_e status_q, status_d;

  logic [2*DimW-1:0] area;
  logic              accept;
  logic              cfg_write;
  mstm_pkg::edge_t   edge_dec;

  // Label memory: one write port, one registered read port.
  logic [CellW-1:0]  label_mem [mstm_pkg::NumCells];
  logic [CellW-1:0]  rd_addr;
  logic [CellW-1:0]  rd_data_q;
  logic              mem_we;
  logic [CellW-1:0]  wr_addr;
  logic [CellW-1:0]  wr_data;

  mstm_edge_decode u_edge_decode (
    .cell_row_i  (cell_row_i),
    .cell_col_i  (cell_col_i),
    .direction_i (direction_i),
    .num_rows_i  (rows_q),
    .num_cols_i  (cols_q),
    .edge_o      (edge_dec)
  );

  assign busy_o      = (state_q != S_IDLE);
  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  assign area        = {{DimW{1'b0}}, rows_q} * {{DimW{1'b0}}, cols_q};

  // Read address per state. During a merge the next entry is read while the
  // current one is written back, so the two never share an address.
  always_comb begin
    unique case (state_q)
      S_IDLE:    rd_addr = edge_dec.addr_a;
      S_READ_B:  rd_addr = addr_b_q;
      S_COMPARE: rd_addr = '0;
      S_MERGE:   rd_addr = idx_q + CellW'(1);
      S_CLEAR:   rd_addr = idx_q;
      default:   rd_addr = idx_q;
    endcase
  end

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = idx_q;
    wr_data = idx_q;
    if (state_q == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state_q == S_MERGE) begin
      mem_we  = (rd_data_q == b_q);
      wr_data = a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      label_mem[wr_addr] <= wr_data;
    end
    rd_data_q <= label_mem[rd_addr];
  end

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    a_d      = a_q;
    b_d      = b_q;
    addr_b_d = addr_b_q;
    report_d = report_q;
    count_d  = count_q;
    rows_d   = rows_q;
    cols_d   = cols_q;
    done_d   = 1'b0;
    status_d = status_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (kind_i == mstm_pkg::KIND_CLEAR) begin
            state_d  = S_CLEAR;
            idx_d    = '0;
            report_d = 1'b1;
          end else if (count_q <= CountW'(1)) begin
            done_d   = 1'b1;
            status_d = mstm_pkg::ST_COMPLETE;
          end else if (edge_dec.out_of_grid) begin
            done_d   = 1'b1;
            status_d = mstm_pkg::ST_OUT_OF_GRID;
          end else begin
            state_d  = S_READ_B;
            addr_b_d = edge_dec.addr_b;
          end
        end
      end
      S_READ_B: begin
        a_d     = rd_data_q;
        state_d = S_COMPARE;
      end
      S_COMPARE: begin
        if (rd_data_q == a_q) begin
          done_d   = 1'b1;
          status_d = mstm_pkg::ST_SAME_CLUSTER;
          state_d  = S_IDLE;
        end else begin
          b_d     = rd_data_q;
          idx_d   = '0;
          state_d = S_MERGE;
        end
      end
      S_MERGE: begin
        idx_d = idx_q + CellW'(1);
        if (idx_q == LastCell) begin
          done_d   = 1'b1;
          status_d = mstm_pkg::ST_ACCEPTED;
          count_d  = count_q - CountW'(1);
          state_d  = S_IDLE;
        end
      end
      S_CLEAR: begin
        idx_d = idx_q + CellW'(1);
        if (idx_q == LastCell) begin
          count_d = area[CountW-1:0];
          state_d = S_IDLE;
          if (report_q) begin
            done_d   = 1'b1;
            status_d = mstm_pkg::ST_CLEARED;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A size change restarts the clearing pass without reporting a result.
    if (cfg_write && (cfg_index_i == mstm_pkg::REG_ROWS ||
                      cfg_index_i == mstm_pkg::REG_COLS)) begin
      if (cfg_index_i == mstm_pkg::REG_ROWS) begin
        rows_d = mstm_pkg::clamp_dim(cfg_data_i, RowsCap);
      end else begin
        cols_d = mstm_pkg::clamp_dim(cfg_data_i, ColsCap);
      end
      state_d  = S_CLEAR;
      idx_d    = '0;
      report_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      idx_q    <= '0;
      report_q <= 1'b0;
      count_q  <= CountW'(mstm_pkg::MaxRows * mstm_pkg::MaxCols);
      rows_q   <= RowsCap;
      cols_q   <= ColsCap;
      done_q   <= 1'b0;
      status_q <= mstm_pkg::ST_CLEARED;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      report_q <= report_d;
      count_q  <= count_d;
      rows_q   <= rows_d;
      cols_q   <= cols_d;
      done_q   <= done_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    b_q      <= b_d;
    addr_b_q <= addr_b_d;
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign maze_done_o     = (count_q == CountW'(1));
  assign clusters_left_o = count_q;

  `MSTM_ASSERT(a_merge_distinct, (state_q == S_MERGE) |-> (a_q != b_q), "merge with equal labels")
  `MSTM_ASSERT(a_idle_no_write, !busy_o |-> !mem_we, "label write while idle")
  `MSTM_ASSERT(a_count_bound, count_q <= CountW'(mstm_pkg::NumCells), "cluster count too large")
  `MSTM_ASSERT(a_merge_dec, (done_o && status_o == mstm_pkg::ST_ACCEPTED) |-> ((count_q + CountW'(1)) == $past(count_q)), "merge did not drop count by one")
  `MSTM_ASSERT_NEXT(a_complete_fast, (accept && kind_i == mstm_pkg::KIND_EDGE && count_q <= CountW'(1)), (done_o && status_o == mstm_pkg::ST_COMPLETE), "complete maze not refused at once")

endmodule

`default_nettype wire
